@@ sv/mbdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbdc_pkg
// Shared types, register indexes, command codes and the duty conversion for
// the motion and battery dimming controller.
// ----------------------------------------------------------------------------
package mbdc_pkg;

   localparam int unsigned DUTY_MAX = 8191;
   localparam int unsigned PCT_LIMIT = 100;

   // floor(x / 100) is taken as (x * ceil(2^32 / 100)) >> 32, exact here.
   localparam int unsigned RECIP_SHIFT = 32;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) / PCT_LIMIT) + 64'd1;
   localparam longint unsigned DUTY_SCALE = longint'(DUTY_MAX) * RECIP;
   localparam int unsigned PROD_W = 56;

   localparam logic [6:0]  RST_FULL_DUTY = 7'd100;
   localparam logic [6:0]  RST_HALF_DUTY = 7'd50;
   localparam logic [31:0] RST_TIMEOUT   = 32'd30000;
   localparam logic [15:0] RST_DEBOUNCE  = 16'd500;
   localparam logic [15:0] RST_FULL_MV   = 16'd13500;
   localparam logic [15:0] RST_HALF_MV   = 16'd12000;
   localparam logic [15:0] RST_CRIT_MV   = 16'd11000;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_MOTION   = 3'd1,
      CMD_FORCE    = 3'd2,
      CMD_CONTROL  = 3'd3,
      CMD_SHUTDOWN = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_FULL_DUTY = 3'd0,
      CSR_HALF_DUTY = 3'd1,
      CSR_TIMEOUT   = 3'd2,
      CSR_DEBOUNCE  = 3'd3,
      CSR_FULL_MV   = 3'd4,
      CSR_HALF_MV   = 3'd5,
      CSR_CRIT_MV   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] supply_mv;
      logic        ch0_update_valid;
      logic        ch0_request;
      logic        ch1_update_valid;
      logic        ch1_request;
   } req_type;

   typedef struct packed {
      logic        applied;
      logic        ch0_on;
      logic        ch1_on;
      logic [6:0]  level_percent;
      logic [12:0] ch0_pwm_duty;
      logic [12:0] ch1_pwm_duty;
      logic        motion_now;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  full_duty_percent;
      logic [6:0]  half_duty_percent;
      logic [31:0] motion_hold_ms;
      logic [15:0] debounce_ms;
      logic [15:0] full_threshold_mv;
      logic [15:0] half_threshold_mv;
      logic [15:0] critical_threshold_mv;
   } cfg_type;

   function automatic logic [12:0] pct_to_duty(input logic [6:0] pct);
      logic [6:0]        p;
      logic [PROD_W-1:0] prod;
      p = (pct > 7'(PCT_LIMIT)) ? 7'(PCT_LIMIT) : pct;
      prod = PROD_W'(p) * PROD_W'(DUTY_SCALE);
      return prod[RECIP_SHIFT +: 13];
   endfunction

endpackage

@@ sv/mbdc_csr.sv @@
// ----------------------------------------------------------------------------
// mbdc_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mbdc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   output mbdc_pkg::cfg_type      cfg
);
   import mbdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FULL_DUTY: cfg_in.full_duty_percent     = csr_wdata[6:0];
            CSR_HALF_DUTY: cfg_in.half_duty_percent     = csr_wdata[6:0];
            CSR_TIMEOUT:   cfg_in.motion_hold_ms        = csr_wdata;
            CSR_DEBOUNCE:  cfg_in.debounce_ms           = csr_wdata[15:0];
            CSR_FULL_MV:   cfg_in.full_threshold_mv     = csr_wdata[15:0];
            CSR_HALF_MV:   cfg_in.half_threshold_mv     = csr_wdata[15:0];
            CSR_CRIT_MV:   cfg_in.critical_threshold_mv = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_duty_percent     <= RST_FULL_DUTY;
         cfg_ff.half_duty_percent     <= RST_HALF_DUTY;
         cfg_ff.motion_hold_ms        <= RST_TIMEOUT;
         cfg_ff.debounce_ms           <= RST_DEBOUNCE;
         cfg_ff.full_threshold_mv     <= RST_FULL_MV;
         cfg_ff.half_threshold_mv     <= RST_HALF_MV;
         cfg_ff.critical_threshold_mv <= RST_CRIT_MV;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/mbdc_core.sv @@
// ----------------------------------------------------------------------------
// mbdc_core
// Controller state and the per-item update: motion timing, duty selection,
// request latching and the driven outputs with their compare values.
// ----------------------------------------------------------------------------
module mbdc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  mbdc_pkg::req_type      item,
   input  mbdc_pkg::cfg_type      cfg,
   output mbdc_pkg::rsp_type      result
);
   import mbdc_pkg::*;

   logic [31:0] since_ff, since_in;
   logic        motion_ff, motion_in;
   logic        latch0_ff, latch0_in;
   logic        latch1_ff, latch1_in;
   logic        drv0_ff, drv0_in;
   logic        drv1_ff, drv1_in;
   logic [6:0]  pct_ff, pct_in;
   logic        applied;
   logic        motion_eff;
   logic [6:0]  pick;
   logic [12:0] duty;

   always_comb begin
      motion_eff = motion_ff && (since_ff <= cfg.motion_hold_ms);
      if (motion_eff || item.supply_mv >= cfg.full_threshold_mv) begin
         pick = cfg.full_duty_percent;
      end else if (item.supply_mv >= cfg.half_threshold_mv) begin
         pick = cfg.half_duty_percent;
      end else if (item.supply_mv >= cfg.critical_threshold_mv) begin
         pick = cfg.half_duty_percent >> 1;
      end else begin
         pick = '0;
      end
   end

   always_comb begin
      since_in  = since_ff;
      motion_in = motion_ff;
      latch0_in = latch0_ff;
      latch1_in = latch1_ff;
      drv0_in   = drv0_ff;
      drv1_in   = drv1_ff;
      pct_in    = pct_ff;
      applied   = 1'b0;
      unique case (item.command)
         CMD_TICK: begin
            if (since_ff != '1) begin
               since_in = since_ff + 32'd1;
            end
         end
         CMD_MOTION: begin
            if (since_ff > 32'(cfg.debounce_ms)) begin
               motion_in = 1'b1;
               since_in  = '0;
            end
         end
         CMD_FORCE: begin
            motion_in = 1'b1;
            since_in  = '0;
         end
         CMD_CONTROL: begin
            motion_in = motion_eff;
            if (item.ch0_update_valid) begin
               latch0_in = item.ch0_request;
            end
            if (item.ch1_update_valid) begin
               latch1_in = item.ch1_request;
            end
            if (item.ch0_update_valid || item.ch1_update_valid || motion_eff) begin
               drv0_in = latch0_in && (pick != '0);
               drv1_in = latch1_in && (pick != '0);
               pct_in  = pick;
               applied = 1'b1;
            end
         end
         CMD_SHUTDOWN: begin
            drv0_in = 1'b0;
            drv1_in = 1'b0;
            pct_in  = '0;
            applied = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff  <= '0;
         motion_ff <= 1'b0;
         latch0_ff <= 1'b0;
         latch1_ff <= 1'b0;
         drv0_ff   <= 1'b0;
         drv1_ff   <= 1'b0;
         pct_ff    <= '0;
      end else if (fire) begin
         since_ff  <= since_in;
         motion_ff <= motion_in;
         latch0_ff <= latch0_in;
         latch1_ff <= latch1_in;
         drv0_ff   <= drv0_in;
         drv1_ff   <= drv1_in;
         pct_ff    <= pct_in;
      end
   end

   assign duty = pct_to_duty(pct_in);

   always_comb begin
      result.applied       = applied;
      result.ch0_on        = drv0_in;
      result.ch1_on        = drv1_in;
      result.level_percent = pct_in;
      result.ch0_pwm_duty  = drv0_in ? duty : '0;
      result.ch1_pwm_duty  = drv1_in ? duty : '0;
      result.motion_now    = motion_in;
   end

endmodule

@@ sv/motion_battery_dimming_controller.sv @@
// ----------------------------------------------------------------------------
// motion_battery_dimming_controller
// Two-channel LED dimming controller with motion override and battery-based
// duty selection.
//
// An item on the req_ channel carries one command: a millisecond tick, a
// motion edge, a forced motion, a control cycle or a shutdown. Every item
// gives exactly one result on the rsp_ channel, in order, with the driven
// channel states, the stored duty percent, the 13-bit compare values and
// the motion flag. The user writes configuration registers through csr_we,
// csr_index and csr_wdata only while no item is in flight; not enforced here.
//
// An accepted item is held in an input register; once the output register
// can advance, it updates the controller state and its result is loaded
// into the output register and rsp_valid rises. One item is taken per
// cycle for as long as the receiver keeps rsp_ready high.
// When the receiver stalls, the result stays in the output register and one
// more item waits in the input register before req_ready drops.
// Reset clears the controller state, empties both registers and returns
// every configuration register to its default.
// ----------------------------------------------------------------------------
module motion_battery_dimming_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mbdc_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mbdc_pkg::rsp_type      rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import mbdc_pkg::*;

   cfg_type cfg;
   req_type in_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type result;
   logic    advance;
   logic    fire;

   mbdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbdc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_fire_loads: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed item gave no result");

   a_duty_ch0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ch0_on |-> rsp_ff.ch0_pwm_duty == '0)
      else $error("channel 0 off with nonzero duty");

   a_duty_ch1: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.level_percent == '0 |-> rsp_ff.ch1_pwm_duty == '0)
      else $error("channel 1 duty without a level");

endmodule
